FILE: design/lltc_pkg.sv
// lltc_pkg: shared types and timing constants for the lcd line timing controller
`timescale 1ns / 1ps

package lltc_pkg;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_OAMRAM = 2'd3
  } mode_t;

  // configuration register indexes
  localparam logic [1:0] REG_LCD_ENABLE   = 2'd0;
  localparam logic [1:0] REG_STAT_ENABLES = 2'd1;
  localparam logic [1:0] REG_LINE_COMPARE = 2'd2;

  // stat interrupt enable bit positions
  localparam int EN_HBLANK = 0;
  localparam int EN_VBLANK = 1;
  localparam int EN_OAM    = 2;
  localparam int EN_LYC    = 3;

  localparam logic [9:0] OAM_END_TIME    = 10'd80;
  localparam logic [9:0] XFER_END_TIME   = 10'd252;
  localparam logic [9:0] LINE_TIME       = 10'd456;
  localparam logic [7:0] VISIBLE_LINES   = 8'd144;
  localparam logic [7:0] LAST_VBLANK_LINE = 8'd153;

  typedef struct packed {
    logic       lcd_enable;
    logic [3:0] stat_int_enables;
    logic [7:0] line_compare;
  } cfg_t;

  typedef struct packed {
    logic [9:0] scan_time;
    logic [7:0] line_counter;
    mode_t      mode;
    logic       coincidence;
    logic       hblank;
    logic       vsync;
  } timing_state_t;

  typedef struct packed {
    mode_t      lcd_mode;
    logic [7:0] current_line;
    logic       coincidence;
    logic       vblank_irq;
    logic       stat_irq;
    logic       draw_line;
    logic [7:0] draw_line_number;
    logic       in_hblank;
    logic       in_vsync;
  } result_t;

endpackage

FILE: design/lltc_step.sv
// lltc_step: next-state and result logic for one elapsed-cycles report
`timescale 1ns / 1ps

module lltc_step import lltc_pkg::*; (
  input  timing_state_t state,
  input  cfg_t          cfg,
  input  logic [7:0]    elapsed_cycles,
  output timing_state_t state_next,
  output result_t       result
);

  logic [9:0] sum;
  logic       end_line;
  logic       visible;
  logic       first_vblank;
  logic       wrap;
  logic       lyc_match;
  logic       stat_hblank;
  logic       stat_line;
  mode_t      mode_mid;
  logic       hblank_mid;

  always_comb begin
    sum = state.scan_time + {2'b00, elapsed_cycles};

    // at most one mode change before the end of line check
    mode_mid    = state.mode;
    hblank_mid  = state.hblank;
    stat_hblank = 1'b0;
    if (state.mode == MODE_OAM) begin
      if (sum >= OAM_END_TIME) mode_mid = MODE_OAMRAM;
    end else if (state.mode == MODE_OAMRAM) begin
      if (sum >= XFER_END_TIME) begin
        mode_mid    = MODE_HBLANK;
        hblank_mid  = 1'b1;
        stat_hblank = cfg.lcd_enable & cfg.stat_int_enables[EN_HBLANK];
      end
    end

    end_line     = (sum >= LINE_TIME);
    visible      = (state.line_counter < VISIBLE_LINES);
    first_vblank = (state.line_counter == VISIBLE_LINES);
    wrap         = (state.line_counter > LAST_VBLANK_LINE);
    lyc_match    = (cfg.line_compare == state.line_counter);

    state_next = state;
    state_next.scan_time = end_line ? (sum - LINE_TIME) : sum;
    state_next.mode      = mode_mid;
    state_next.hblank    = hblank_mid;
    stat_line = 1'b0;
    result.vblank_irq       = 1'b0;
    result.draw_line        = 1'b0;
    result.draw_line_number = 8'd0;

    if (end_line) begin
      if (visible) begin
        result.draw_line        = cfg.lcd_enable;
        result.draw_line_number = cfg.lcd_enable ? state.line_counter : 8'd0;
        state_next.mode         = MODE_OAM;
        state_next.hblank       = 1'b0;
      end else if (first_vblank) begin
        state_next.mode   = MODE_VBLANK;
        result.vblank_irq = 1'b1;
        stat_line         = cfg.lcd_enable & cfg.stat_int_enables[EN_VBLANK];
        state_next.vsync  = 1'b1;
      end else if (wrap) begin
        stat_line        = cfg.lcd_enable & cfg.stat_int_enables[EN_OAM];
        state_next.vsync = 1'b0;
      end
      // compare uses the line number before it advances, not gated by lcd enable
      state_next.coincidence = lyc_match;
      if (lyc_match && cfg.stat_int_enables[EN_LYC]) stat_line = 1'b1;
      state_next.line_counter = wrap ? 8'd0 : state.line_counter + 8'd1;
    end

    result.stat_irq     = stat_hblank | stat_line;
    result.lcd_mode     = state_next.mode;
    result.current_line = state_next.line_counter;
    result.coincidence  = state_next.coincidence;
    result.in_hblank    = state_next.hblank;
    result.in_vsync     = state_next.vsync;
  end

endmodule

FILE: design/lcd_line_timing_controller_core.sv
// lcd_line_timing_controller_core: lcd mode and line sequencer with registered result
`timescale 1ns / 1ps
// a result is registered and appears on the out channel in the cycle after its transaction is accepted
// throughput: one transaction per cycle; the single result register stalls the input
//   only while it holds a result that the output side is stalling
// the whole step is one counter add, one subtract and a few compares ahead of that register
// reset (rst, synchronous): timing state and configuration clear to zero, mode hblank,
//   no result pending

module lcd_line_timing_controller_core import lltc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] elapsed_cycles,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] lcd_mode,
  output logic [7:0] current_line,
  output logic       coincidence,
  output logic       vblank_irq,
  output logic       stat_irq,
  output logic       draw_line,
  output logic [7:0] draw_line_number,
  output logic       in_hblank,
  output logic       in_vsync,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t          cfg;
  timing_state_t state;
  timing_state_t state_next;
  result_t       step_result;
  result_t       result;
  logic          in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LCD_ENABLE:   cfg.lcd_enable       <= cfg_data[0];
        REG_STAT_ENABLES: cfg.stat_int_enables <= cfg_data[3:0];
        REG_LINE_COMPARE: cfg.line_compare     <= cfg_data;
        default: ;
      endcase
    end
  end

  lltc_step u_step (
    .state          (state),
    .cfg            (cfg),
    .elapsed_cycles (elapsed_cycles),
    .state_next     (state_next),
    .result         (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.scan_time    <= '0;
      state.line_counter <= '0;
      state.mode         <= MODE_HBLANK;
      state.coincidence  <= 1'b0;
      state.hblank       <= 1'b0;
      state.vsync        <= 1'b0;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      result <= step_result;
    end
  end

  assign lcd_mode         = result.lcd_mode;
  assign current_line     = result.current_line;
  assign coincidence      = result.coincidence;
  assign vblank_irq       = result.vblank_irq;
  assign stat_irq         = result.stat_irq;
  assign draw_line        = result.draw_line;
  assign draw_line_number = result.draw_line_number;
  assign in_hblank        = result.in_hblank;
  assign in_vsync         = result.in_vsync;

  // scan time always ends a step below one line period
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state.scan_time < LINE_TIME)
    else $error("scan time out of range");

  // line counter never passes the wrap point
  a_line_range: assert property (@(posedge clk) disable iff (rst)
    state.line_counter <= LAST_VBLANK_LINE + 8'd1)
    else $error("line counter out of range");

  // a draw strobe always leaves the block in oam search, and the line it draws is a visible one
  a_draw_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && draw_line |->
      lcd_mode == MODE_OAM && current_line <= VISIBLE_LINES && draw_line_number < VISIBLE_LINES)
    else $error("draw strobe outside oam search");

  // the vblank interrupt comes with entry to vblank on line 145
  a_vblank_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && vblank_irq |->
      lcd_mode == MODE_VBLANK && in_vsync && current_line == VISIBLE_LINES + 8'd1)
    else $error("vblank interrupt without vblank entry");

  // a held result does not change while the output side stalls
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(result))
    else $error("stalled result changed");

endmodule
